// ===== src/grs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grs_pkg: shared types and constants for the graph reachability search
// Node id widths, store sizes, opcode values and the sequencer state type.
// ----------------------------------------------------------------------------
package grs_pkg;

  // Node ids are 1..NODES; id 0 is never a node
  localparam int ID_W   = 6;
  localparam int NODES  = 63;
  localparam int SLOTS  = 64;          // rows / bits of the adjacency store
  localparam int QPTR_W = 7;           // queue head / tail width

  localparam logic [ID_W-1:0]  ID_FIRST = ID_W'(1);
  localparam logic [ID_W-1:0]  ID_LAST  = ID_W'(SLOTS - 1);
  localparam logic [ID_W-1:0]  ID_NODES = ID_W'(NODES);
  localparam logic [SLOTS-1:0] ROW_ONE  = SLOTS'(1);

  // Input opcodes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_RUN  = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_WR,
    ST_POP,
    ST_FETCH,
    ST_ROW,
    ST_SCAN,
    ST_EMIT_CNT,
    ST_EMIT_ID,
    ST_EMIT_BAD
  } state_t;

endpackage

// ===== src/grs_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grs_stream_if: valid/ready channels of the graph reachability search
// One interface for the edge/run input beats and one for the result beats.
// ----------------------------------------------------------------------------
interface grs_in_if;
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [grs_pkg::ID_W-1:0] from_node;
  logic [grs_pkg::ID_W-1:0] to_node;

  modport source (output valid, output func, output from_node, output to_node,
                  input ready);
  modport sink   (input valid, input func, input from_node, input to_node,
                  output ready);
endinterface

interface grs_out_if;
  logic                     valid;
  logic                     ready;
  logic                     is_count;
  logic [grs_pkg::ID_W-1:0] value;
  logic                     last;

  modport source (output valid, output is_count, output value, output last,
                  input ready);
  modport sink   (input valid, input is_count, input value, input last,
                  output ready);
endinterface

// ===== src/graph_reachability_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_reachability_search: breadth-first reachability over a directed graph
// Edges are loaded into an adjacency bit store; a run beat walks the graph
// from start_node and streams the reachable count, then the ids in order.
// ----------------------------------------------------------------------------
//  channel   dir  handshake         payload
//  in_bus    in   valid / ready     func, from_node, to_node
//  out_bus   out  valid / ready     is_count, value, last
//  cfg       in   cfg_wr_en         cfg_wr_data (start_node)
//
//  Edge load: row read, then row write in ST_LD_WR; an edge with a bad id is dropped.
//  Run: a seed step, then per reachable node a pop, a row read and a one-bit scan
//  of the row by the shared bit-test step, then an empty pop, then the count beat
//  and the ids as the id counter sweeps the visited mask; bad start: ST_EMIT_BAD.
//  Reset and the end of each run clear the per-row valid bits at once.
//  Output stalls hold emission; a new beat is taken while the last result waits.
// ----------------------------------------------------------------------------
module graph_reachability_search (
  input  logic                     clk,
  input  logic                     rst_n,
  grs_in_if.sink                   in_bus,
  grs_out_if.source                out_bus,
  input  logic                     cfg_wr_en,
  input  logic [grs_pkg::ID_W-1:0] cfg_wr_data
);

  localparam int SLOTS  = grs_pkg::SLOTS;
  localparam int ID_W   = grs_pkg::ID_W;
  localparam int QPTR_W = grs_pkg::QPTR_W;

  // Memories
  logic [SLOTS-1:0] adj_mem [SLOTS];
  logic [ID_W-1:0]  q_mem   [SLOTS];

  // Registers
  grs_pkg::state_t  state_r, state_nxt;
  logic [ID_W-1:0]  start_r;
  logic [SLOTS-1:0] row_vld_r, row_vld_nxt;
  logic [SLOTS-1:0] visited_r, visited_nxt;
  logic [SLOTS-1:0] fresh_r, fresh_nxt;
  logic [QPTR_W-1:0] head_r, head_nxt;
  logic [QPTR_W-1:0] tail_r, tail_nxt;
  logic [ID_W-1:0]  count_r, count_nxt;
  logic [ID_W-1:0]  remain_r, remain_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic [ID_W-1:0]  ld_from_r, ld_from_nxt;
  logic [ID_W-1:0]  ld_to_r, ld_to_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_is_count_r, out_is_count_nxt;
  logic [ID_W-1:0]  out_value_r, out_value_nxt;
  logic             out_last_r, out_last_nxt;
  logic [SLOTS-1:0] adj_rdata_r;
  logic             adj_rvld_r;
  logic [ID_W-1:0]  q_rdata_r;

  // Memory control
  logic             adj_we;
  logic [ID_W-1:0]  adj_raddr;
  logic [SLOTS-1:0] adj_wdata;
  logic             q_we;
  logic [ID_W-1:0]  q_waddr;
  logic [ID_W-1:0]  q_wdata;
  logic [SLOTS-1:0] row_data;
  logic             out_free;
  logic             in_ready;
  logic             ld_ok;

  assign in_bus.ready     = in_ready;
  assign out_bus.valid    = out_valid_r;
  assign out_bus.is_count = out_is_count_r;
  assign out_bus.value    = out_value_r;
  assign out_bus.last     = out_last_r;

  assign out_free  = !out_valid_r || out_bus.ready;
  assign row_data  = adj_rvld_r ? adj_rdata_r : '0;
  assign adj_raddr = (state_r == grs_pkg::ST_IDLE) ? in_bus.from_node : q_rdata_r;
  assign adj_wdata = row_data | (grs_pkg::ROW_ONE << ld_to_r);
  assign ld_ok     = (in_bus.from_node != '0) && (in_bus.from_node <= grs_pkg::ID_NODES) &&
                     (in_bus.to_node != '0) && (in_bus.to_node <= grs_pkg::ID_NODES);

  // Adjacency store: one read and one write port, registered read
  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[ld_from_r] <= adj_wdata;
    end
    adj_rdata_r <= adj_mem[adj_raddr];
    adj_rvld_r  <= row_vld_r[adj_raddr];
  end

  // Work queue: written at tail, read at head
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    q_rdata_r <= q_mem[head_r[ID_W-1:0]];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= grs_pkg::ST_IDLE;
      start_r     <= grs_pkg::ID_FIRST;
      row_vld_r   <= '0;
      visited_r   <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_vld_r   <= row_vld_nxt;
      visited_r   <= visited_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        start_r <= cfg_wr_data;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    fresh_r        <= fresh_nxt;
    count_r        <= count_nxt;
    remain_r       <= remain_nxt;
    id_r           <= id_nxt;
    ld_from_r      <= ld_from_nxt;
    ld_to_r        <= ld_to_nxt;
    out_is_count_r <= out_is_count_nxt;
    out_value_r    <= out_value_nxt;
    out_last_r     <= out_last_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt        = state_r;
    row_vld_nxt      = row_vld_r;
    visited_nxt      = visited_r;
    fresh_nxt        = fresh_r;
    head_nxt         = head_r;
    tail_nxt         = tail_r;
    count_nxt        = count_r;
    remain_nxt       = remain_r;
    id_nxt           = id_r;
    ld_from_nxt      = ld_from_r;
    ld_to_nxt        = ld_to_r;
    out_valid_nxt    = out_valid_r && !out_bus.ready;
    out_is_count_nxt = out_is_count_r;
    out_value_nxt    = out_value_r;
    out_last_nxt     = out_last_r;
    adj_we           = 1'b0;
    q_we             = 1'b0;
    q_waddr          = tail_r[ID_W-1:0];
    q_wdata          = id_r;
    in_ready         = 1'b0;

    case (state_r)
      grs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_bus.valid) begin
          if (in_bus.func == grs_pkg::FUNC_RUN) begin
            if (start_r == '0 || start_r > grs_pkg::ID_NODES) begin
              state_nxt = grs_pkg::ST_EMIT_BAD;
            end else begin
              // seed the queue with the start node
              visited_nxt = grs_pkg::ROW_ONE << start_r;
              count_nxt   = grs_pkg::ID_FIRST;
              q_we        = 1'b1;
              q_waddr     = '0;
              q_wdata     = start_r;
              head_nxt    = '0;
              tail_nxt    = QPTR_W'(1);
              state_nxt   = grs_pkg::ST_POP;
            end
          end else if (ld_ok) begin
            ld_from_nxt = in_bus.from_node;
            ld_to_nxt   = in_bus.to_node;
            state_nxt   = grs_pkg::ST_LD_WR;
          end
        end
      end

      // row read came back; merge the new edge bit
      grs_pkg::ST_LD_WR: begin
        adj_we                 = 1'b1;
        row_vld_nxt[ld_from_r] = 1'b1;
        state_nxt              = grs_pkg::ST_IDLE;
      end

      grs_pkg::ST_POP: begin
        if (head_r == tail_r) begin
          state_nxt = grs_pkg::ST_EMIT_CNT;
        end else begin
          head_nxt  = head_r + QPTR_W'(1);
          state_nxt = grs_pkg::ST_FETCH;
        end
      end

      // queue entry valid; adjacency row read issued this cycle
      grs_pkg::ST_FETCH: begin
        state_nxt = grs_pkg::ST_ROW;
      end

      grs_pkg::ST_ROW: begin
        fresh_nxt = row_data & ~visited_r;
        id_nxt    = grs_pkg::ID_FIRST;
        state_nxt = grs_pkg::ST_SCAN;
      end

      // one bit of the fresh row per cycle
      grs_pkg::ST_SCAN: begin
        if (fresh_r[id_r]) begin
          visited_nxt[id_r] = 1'b1;
          q_we              = 1'b1;
          tail_nxt          = tail_r + QPTR_W'(1);
          count_nxt         = count_r + ID_W'(1);
        end
        if (id_r == grs_pkg::ID_LAST) begin
          state_nxt = grs_pkg::ST_POP;
        end else begin
          id_nxt = id_r + ID_W'(1);
        end
      end

      grs_pkg::ST_EMIT_CNT: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_is_count_nxt = 1'b1;
          out_value_nxt    = count_r;
          out_last_nxt     = 1'b0;
          remain_nxt       = count_r;
          id_nxt           = grs_pkg::ID_FIRST;
          state_nxt        = grs_pkg::ST_EMIT_ID;
        end
      end

      // sweep the visited mask in ascending id order
      grs_pkg::ST_EMIT_ID: begin
        if (visited_r[id_r]) begin
          if (out_free) begin
            out_valid_nxt    = 1'b1;
            out_is_count_nxt = 1'b0;
            out_value_nxt    = id_r;
            out_last_nxt     = (remain_r == ID_W'(1));
            remain_nxt       = remain_r - ID_W'(1);
            id_nxt           = id_r + ID_W'(1);
            if (remain_r == ID_W'(1)) begin
              row_vld_nxt = '0;
              visited_nxt = '0;
              head_nxt    = '0;
              tail_nxt    = '0;
              state_nxt   = grs_pkg::ST_IDLE;
            end
          end
        end else begin
          id_nxt = id_r + ID_W'(1);
        end
      end

      grs_pkg::ST_EMIT_BAD: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_is_count_nxt = 1'b1;
          out_value_nxt    = '0;
          out_last_nxt     = 1'b1;
          row_vld_nxt      = '0;
          visited_nxt      = '0;
          head_nxt         = '0;
          tail_nxt         = '0;
          state_nxt        = grs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = grs_pkg::ST_IDLE;
      end
    endcase
  end

  // Checks
  a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r)
    else $error("queue head passed tail");

  a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r < QPTR_W'(SLOTS))
    else $error("queue tail overflow");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == grs_pkg::ST_POP) |-> (32'(count_r) == $countones(visited_r)))
    else $error("reachable count does not match visited mask");

  a_bad_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_is_count_r && out_last_r) |-> (out_value_r == '0))
    else $error("count beat flagged last with nonzero count");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_nxt && out_last_nxt && !out_valid_r) |=> (row_vld_r == '0))
    else $error("adjacency store not cleared at end of run");

endmodule
